// ===== hdl/mouse_delta_conditioner_core_defines.svh =====
// Assertion macros shared by the mouse delta conditioner modules.
`ifndef MOUSE_DELTA_CONDITIONER_CORE_DEFINES_SVH
`define MOUSE_DELTA_CONDITIONER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MDC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mdc assertion failed");

// Next-cycle implication, checked out of reset.
`define MDC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mdc assertion failed");

`endif

// ===== hdl/mdc_pkg.sv =====
// Types and constants shared by the mouse delta conditioner modules.
package mdc_pkg;

    localparam int DELTA_W = 16;
    localparam int SUM_W   = DELTA_W + 1;
    localparam int MOVE_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int DZ_W    = 16;
    localparam int BIAS_W  = 8;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 16;

    // Product widths: sum x sensitivity, then x axis gain.
    localparam int P1_W    = SUM_W + GAIN_W;
    localparam int P2_W    = P1_W + GAIN_W;
    // 16 / (2 * 65536) is a right shift by 13.
    localparam int SCALE_SHIFT = 13;
    localparam int Q_W     = P2_W - SCALE_SHIFT;

    localparam int LANE_STAGES = 5;
    localparam int DIV_STEPS   = MOVE_W;
    localparam int CNT_W       = $clog2(DIV_STEPS);

    localparam logic [MOVE_W-1:0] MOVE_MAX = {1'b0, {(MOVE_W-1){1'b1}}};
    localparam logic [MOVE_W-1:0] MOVE_MIN = {1'b1, {(MOVE_W-1){1'b0}}};

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_SMOOTH = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_SENS   = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_XGAIN  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_YGAIN  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_DZONE  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_BIAS   = 3'd5;

    typedef struct packed {
        logic              smooth;
        logic [GAIN_W-1:0] sens;
        logic [GAIN_W-1:0] x_gain;
        logic [GAIN_W-1:0] y_gain;
        logic [DZ_W-1:0]   deadzone;
        logic [BIAS_W-1:0] bias;
    } t_cfg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,
        S_MERGE,
        S_DONE
    } t_top_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_DIV,
        M_FIX
    } t_merge_state;

    // Control flags of the merge stage sequencer.
    typedef struct packed {
        logic load;
        logic step;
        logic fix;
    } t_merge_ctl;

endpackage

// ===== hdl/mdc_lane.sv =====
// One axis lane: scales the summed delta, saturates it and applies the deadzone.
module mdc_lane (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [mdc_pkg::SUM_W-1:0]     i_s2,
    input  logic signed [mdc_pkg::GAIN_W-1:0]    i_gain,
    input  mdc_pkg::t_cfg                        i_cfg,
    output logic                                 o_done,
    output logic signed [mdc_pkg::MOVE_W-1:0]    o_move
);

    logic [mdc_pkg::LANE_STAGES-1:0]          r_vld;
    logic signed [mdc_pkg::SUM_W-1:0]         r_s2;
    logic signed [mdc_pkg::P1_W-1:0]          r_p1;
    logic signed [mdc_pkg::P2_W-1:0]          r_p2;
    logic signed [mdc_pkg::MOVE_W-1:0]        r_sat;
    logic signed [mdc_pkg::MOVE_W-1:0]        r_res;

    logic signed [mdc_pkg::P2_W-1:0]          w_adj;
    logic signed [mdc_pkg::Q_W-1:0]           w_q;
    logic signed [mdc_pkg::MOVE_W-1:0]        n_sat;
    logic signed [mdc_pkg::MOVE_W:0]          w_dec;
    logic signed [mdc_pkg::MOVE_W:0]          w_inc;
    logic signed [mdc_pkg::MOVE_W-1:0]        n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[mdc_pkg::LANE_STAGES-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s2 <= i_s2;
        end
        r_p1  <= mdc_pkg::P1_W'(r_s2) * mdc_pkg::P1_W'($signed(i_cfg.sens));
        r_p2  <= mdc_pkg::P2_W'(r_p1) * mdc_pkg::P2_W'(i_gain);
        r_sat <= n_sat;
        r_res <= n_res;
    end

    // A negative product is biased before the shift so that it truncates toward zero.
    always_comb begin
        w_adj = r_p2 + (r_p2[mdc_pkg::P2_W-1] ?
                        mdc_pkg::P2_W'((1 << mdc_pkg::SCALE_SHIFT) - 1) : '0);
        w_q   = w_adj[mdc_pkg::P2_W-1:mdc_pkg::SCALE_SHIFT];
        if (!w_q[mdc_pkg::Q_W-1] && (|w_q[mdc_pkg::Q_W-2:mdc_pkg::MOVE_W-1])) begin
            n_sat = mdc_pkg::MOVE_MAX;
        end else if (w_q[mdc_pkg::Q_W-1] && !(&w_q[mdc_pkg::Q_W-2:mdc_pkg::MOVE_W-1])) begin
            n_sat = mdc_pkg::MOVE_MIN;
        end else begin
            n_sat = w_q[mdc_pkg::MOVE_W-1:0];
        end
    end

    // Deadzone pulls the value toward zero and never flips its sign.
    always_comb begin
        w_dec = (mdc_pkg::MOVE_W+1)'(r_sat)
              - $signed({{(mdc_pkg::MOVE_W+1-mdc_pkg::DZ_W){1'b0}}, i_cfg.deadzone});
        w_inc = (mdc_pkg::MOVE_W+1)'(r_sat)
              + $signed({{(mdc_pkg::MOVE_W+1-mdc_pkg::DZ_W){1'b0}}, i_cfg.deadzone});
        if (r_sat > 0) begin
            n_res = (w_dec > 0) ? w_dec[mdc_pkg::MOVE_W-1:0] : '0;
        end else if (r_sat < 0) begin
            n_res = (w_inc < 0) ? w_inc[mdc_pkg::MOVE_W-1:0] : '0;
        end else begin
            n_res = '0;
        end
    end

    assign o_done = r_vld[mdc_pkg::LANE_STAGES-1];
    assign o_move = r_res;

endmodule

// ===== hdl/mdc_merge.sv =====
// Merge stage: picks the weaker axis and divides it by a nonzero bias, one quotient bit per cycle.
`include "mouse_delta_conditioner_core_defines.svh"

module mdc_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [mdc_pkg::MOVE_W-1:0] i_mx,
    input  logic signed [mdc_pkg::MOVE_W-1:0] i_my,
    input  mdc_pkg::t_cfg                     i_cfg,
    output logic                              o_done,
    output logic signed [mdc_pkg::MOVE_W-1:0] o_mx,
    output logic signed [mdc_pkg::MOVE_W-1:0] o_my
);

    mdc_pkg::t_merge_state r_state, n_state;
    mdc_pkg::t_merge_ctl   w_ctl;

    logic                              r_done;
    logic [mdc_pkg::CNT_W-1:0]         r_cnt;
    logic                              r_sel_y;
    logic                              r_neg;
    logic [mdc_pkg::MOVE_W-1:0]        r_quo;
    logic [mdc_pkg::BIAS_W-1:0]        r_rem;
    logic signed [mdc_pkg::MOVE_W-1:0] r_mx;
    logic signed [mdc_pkg::MOVE_W-1:0] r_my;

    logic [mdc_pkg::MOVE_W-1:0]        w_ax;
    logic [mdc_pkg::MOVE_W-1:0]        w_ay;
    logic                              w_sel_y;
    logic [mdc_pkg::BIAS_W:0]          w_sh;
    logic [mdc_pkg::BIAS_W:0]          w_diff;
    logic                              w_ge;
    logic [mdc_pkg::MOVE_W-1:0]        w_res;
    logic                              w_last;

    always_comb begin
        w_ax    = i_mx[mdc_pkg::MOVE_W-1] ? (-i_mx) : i_mx;
        w_ay    = i_my[mdc_pkg::MOVE_W-1] ? (-i_my) : i_my;
        // Equal magnitudes divide the horizontal axis.
        w_sel_y = w_ax > w_ay;
        w_sh    = {r_rem, r_quo[mdc_pkg::MOVE_W-1]};
        w_diff  = w_sh - {1'b0, i_cfg.bias};
        w_ge    = w_sh >= {1'b0, i_cfg.bias};
        w_res   = r_neg ? (-r_quo) : r_quo;
        w_last  = r_cnt == mdc_pkg::CNT_W'(mdc_pkg::DIV_STEPS - 1);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mdc_pkg::M_IDLE: begin
                if (i_start && (i_cfg.bias != '0)) begin
                    n_state = mdc_pkg::M_DIV;
                end
            end
            mdc_pkg::M_DIV: begin
                if (w_last) begin
                    n_state = mdc_pkg::M_FIX;
                end
            end
            mdc_pkg::M_FIX: begin
                n_state = mdc_pkg::M_IDLE;
            end
            default: begin
                n_state = mdc_pkg::M_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctl = '0;
        case (r_state)
            mdc_pkg::M_IDLE: begin
                w_ctl.load = i_start;
            end
            mdc_pkg::M_DIV: begin
                w_ctl.step = 1'b1;
            end
            mdc_pkg::M_FIX: begin
                w_ctl.fix = 1'b1;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mdc_pkg::M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (w_ctl.load && (i_cfg.bias == '0)) || w_ctl.fix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_mx    <= i_mx;
            r_my    <= i_my;
            r_sel_y <= w_sel_y;
            r_neg   <= w_sel_y ? i_my[mdc_pkg::MOVE_W-1] : i_mx[mdc_pkg::MOVE_W-1];
            r_quo   <= w_sel_y ? w_ay : w_ax;
            r_rem   <= '0;
            r_cnt   <= '0;
        end
        if (w_ctl.step) begin
            r_rem <= w_ge ? w_diff[mdc_pkg::BIAS_W-1:0] : w_sh[mdc_pkg::BIAS_W-1:0];
            r_quo <= {r_quo[mdc_pkg::MOVE_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (w_ctl.fix) begin
            if (r_sel_y) begin
                r_my <= w_res;
            end else begin
                r_mx <= w_res;
            end
        end
    end

    assign o_done = r_done;
    assign o_mx   = r_mx;
    assign o_my   = r_my;

    `MDC_ASSERT_IMP(a_start_when_idle, i_start, r_state == mdc_pkg::M_IDLE)
    `MDC_ASSERT_NXT(a_start_moves_on, i_start, (r_state == mdc_pkg::M_DIV) || r_done)
    `MDC_ASSERT_NXT(a_done_single, r_done, !r_done)
    `MDC_ASSERT_IMP(a_fix_after_div, r_state == mdc_pkg::M_FIX,
                    $past(r_state) == mdc_pkg::M_DIV)

endmodule

// ===== hdl/mouse_delta_conditioner_core.sv =====
// Top level of the mouse delta conditioner: config registers, axis lanes, merge, output register.
//
//  channel   | dir | handshake                                   | payload
//  ----------+-----+---------------------------------------------+-----------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready          | tdata: delta_x, delta_y; tuser: active
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready          | tdata: move_x, move_y
//  cfg       | in  | i_cfg_valid / o_cfg_ready (always ready)   | i_cfg_index, i_cfg_data
//
// An active beat is accepted, scaled in the two axis lanes, merged (passed through when the
// bias is zero, else divided by the serial divider, one quotient bit per cycle) and then
// loaded into the output register. An inactive beat skips the lanes and the merge.
// The input is taken again once the result sits in the output register, so a stalled
// output holds at most one result while the next beat is worked on.
// Reset is synchronous, active low, and needs no clearing pass.
`include "mouse_delta_conditioner_core_defines.svh"

module mouse_delta_conditioner_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [31:0]                   i_s_axis_tdata,  // [15:0] delta_x, [31:16] delta_y
    input  logic                          i_s_axis_tuser,  // [0] active
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [63:0]                   o_m_axis_tdata,  // [31:0] move_x, [63:32] move_y
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mdc_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [mdc_pkg::CDATA_W-1:0]   i_cfg_data
);

    mdc_pkg::t_top_state r_state, n_state;
    mdc_pkg::t_cfg       r_cfg;

    logic signed [mdc_pkg::DELTA_W-1:0] r_prev_x;
    logic signed [mdc_pkg::DELTA_W-1:0] r_prev_y;
    logic                               r_zero;
    logic                               r_out_valid;
    logic [2*mdc_pkg::MOVE_W-1:0]       r_out_data;

    logic                               w_in_accept;
    logic                               w_cfg_accept;
    logic signed [mdc_pkg::DELTA_W-1:0] w_dx;
    logic signed [mdc_pkg::DELTA_W-1:0] w_dy;
    logic signed [mdc_pkg::SUM_W-1:0]   w_s2x;
    logic signed [mdc_pkg::SUM_W-1:0]   w_s2y;
    logic                               w_lane_start;
    logic                               w_merge_start;
    logic                               w_out_load;
    logic                               w_done_x;
    logic                               w_done_y;
    logic signed [mdc_pkg::MOVE_W-1:0]  w_lane_x;
    logic signed [mdc_pkg::MOVE_W-1:0]  w_lane_y;
    logic                               w_merge_done;
    logic signed [mdc_pkg::MOVE_W-1:0]  w_mx;
    logic signed [mdc_pkg::MOVE_W-1:0]  w_my;

    assign o_cfg_ready  = 1'b1;
    assign w_cfg_accept = i_cfg_valid && o_cfg_ready;
    assign w_in_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_dx         = i_s_axis_tdata[mdc_pkg::DELTA_W-1:0];
    assign w_dy         = i_s_axis_tdata[2*mdc_pkg::DELTA_W-1:mdc_pkg::DELTA_W];

    // Sums carry one fraction bit: delta plus previous, or twice the delta.
    always_comb begin
        if (r_cfg.smooth) begin
            w_s2x = mdc_pkg::SUM_W'(w_dx) + mdc_pkg::SUM_W'(r_prev_x);
            w_s2y = mdc_pkg::SUM_W'(w_dy) + mdc_pkg::SUM_W'(r_prev_y);
        end else begin
            w_s2x = {w_dx, 1'b0};
            w_s2y = {w_dy, 1'b0};
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mdc_pkg::S_IDLE: begin
                if (w_in_accept) begin
                    n_state = i_s_axis_tuser ? mdc_pkg::S_SCALE : mdc_pkg::S_DONE;
                end
            end
            mdc_pkg::S_SCALE: begin
                if (w_done_x) begin
                    n_state = mdc_pkg::S_MERGE;
                end
            end
            mdc_pkg::S_MERGE: begin
                if (w_merge_done) begin
                    n_state = mdc_pkg::S_DONE;
                end
            end
            mdc_pkg::S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = mdc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mdc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_lane_start    = 1'b0;
        w_merge_start   = 1'b0;
        w_out_load      = 1'b0;
        case (r_state)
            mdc_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_lane_start    = i_s_axis_tvalid && i_s_axis_tuser;
            end
            mdc_pkg::S_SCALE: begin
                w_merge_start = w_done_x;
            end
            mdc_pkg::S_MERGE: begin
                w_merge_start = 1'b0;
            end
            mdc_pkg::S_DONE: begin
                w_out_load = !r_out_valid || i_m_axis_tready;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= mdc_pkg::S_IDLE;
            r_out_valid     <= 1'b0;
            r_prev_x        <= '0;
            r_prev_y        <= '0;
            r_cfg.smooth    <= 1'b0;
            r_cfg.sens      <= mdc_pkg::GAIN_RESET;
            r_cfg.x_gain    <= mdc_pkg::GAIN_RESET;
            r_cfg.y_gain    <= mdc_pkg::GAIN_RESET;
            r_cfg.deadzone  <= '0;
            r_cfg.bias      <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_lane_start && r_cfg.smooth) begin
                r_prev_x <= w_dx;
                r_prev_y <= w_dy;
            end
            if (w_cfg_accept) begin
                case (i_cfg_index)
                    mdc_pkg::CFG_SMOOTH: r_cfg.smooth   <= i_cfg_data[0];
                    mdc_pkg::CFG_SENS:   r_cfg.sens     <= i_cfg_data;
                    mdc_pkg::CFG_XGAIN:  r_cfg.x_gain   <= i_cfg_data;
                    mdc_pkg::CFG_YGAIN:  r_cfg.y_gain   <= i_cfg_data;
                    mdc_pkg::CFG_DZONE:  r_cfg.deadzone <= i_cfg_data;
                    mdc_pkg::CFG_BIAS:   r_cfg.bias     <= i_cfg_data[mdc_pkg::BIAS_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_zero <= !i_s_axis_tuser;
        end
        if (w_out_load) begin
            r_out_data <= r_zero ? '0 : {w_my, w_mx};
        end
    end

    mdc_lane u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lane_start),
        .i_s2    (w_s2x),
        .i_gain  ($signed(r_cfg.x_gain)),
        .i_cfg   (r_cfg),
        .o_done  (w_done_x),
        .o_move  (w_lane_x)
    );

    mdc_lane u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_lane_start),
        .i_s2    (w_s2y),
        .i_gain  ($signed(r_cfg.y_gain)),
        .i_cfg   (r_cfg),
        .o_done  (w_done_y),
        .o_move  (w_lane_y)
    );

    mdc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_merge_start),
        .i_mx    (w_lane_x),
        .i_my    (w_lane_y),
        .i_cfg   (r_cfg),
        .o_done  (w_merge_done),
        .o_mx    (w_mx),
        .o_my    (w_my)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    `MDC_ASSERT_IMP(a_lanes_in_step, 1'b1, w_done_x == w_done_y)
    `MDC_ASSERT_IMP(a_lane_done_in_scale, w_done_x, r_state == mdc_pkg::S_SCALE)
    `MDC_ASSERT_NXT(a_inactive_skips, w_in_accept && !i_s_axis_tuser,
                    r_state == mdc_pkg::S_DONE)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the mouse delta conditioner core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 500000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_REPORTS = 80;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [mdc_pkg::CIDX_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [mdc_pkg::CIDX_W-1:0] CFG_SPARE7 = 3'd7;

    typedef struct packed {
        logic [mdc_pkg::MOVE_W-1:0] move_y;
        logic [mdc_pkg::MOVE_W-1:0] move_x;
    } t_move;

    typedef enum logic {ROW_CFG, ROW_REPORT} t_row_kind;

    typedef struct {
        t_row_kind                   kind;
        logic [mdc_pkg::CIDX_W-1:0]  idx;
        logic [mdc_pkg::CDATA_W-1:0] val;
        logic [15:0]                 dx;
        logic [15:0]                 dy;
        logic                        active;
        bit                          typed;
        t_move                       typed_move;
    } t_stim_row;

    typedef enum logic [1:0] {RX_OPEN, RX_TOGGLE, RX_SPARSE, RX_HOLD} t_rx_mode;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [31:0]                   i_s_axis_tdata = '0;
    logic                          i_s_axis_tuser = 1'b0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    logic [63:0]                   o_m_axis_tdata;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [mdc_pkg::CIDX_W-1:0]    i_cfg_index = '0;
    logic [mdc_pkg::CDATA_W-1:0]   i_cfg_data = '0;

    // Predictor copy of the registers and the smoothing history.
    logic   smooth_on;
    longint sens_gain, x_axis_gain, y_axis_gain, dead_amount, bias_div;
    longint last_dx, last_dy;

    t_move     expected_moves[$];
    t_stim_row directed_rows[$];

    int fail_count    = 0;
    int cycle_count   = 0;
    int beats_in      = 0;
    int beats_active  = 0;
    int moves_checked = 0;
    int reg_writes    = 0;
    int settings_used = 0;

    t_rx_mode rx_mode = RX_OPEN;
    int       rx_left = 0;

    mouse_delta_conditioner_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [15:0] delta_x, [31:16] delta_y
        .i_s_axis_tuser  (i_s_axis_tuser),   // [0] active
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [31:0] move_x, [63:32] move_y
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results still expected", $realtime,
                     expected_moves.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // Scale one axis: exact product, truncate toward zero, saturate to 32 bits.
    function automatic longint scale_lane(longint s2, longint gain);
        longint v;
        v = (s2 * sens_gain * gain) / 8192;
        if (v > longint'(32'sh7FFF_FFFF))
            v = longint'(32'sh7FFF_FFFF);
        if (v < -longint'(32'sh7FFF_FFFF) - 1)
            v = -longint'(32'sh7FFF_FFFF) - 1;
        return v;
    endfunction

    function automatic longint shrink_dead(longint v);
        if (v > 0)
            return (v - dead_amount > 0) ? v - dead_amount : 0;
        if (v < 0)
            return (v + dead_amount < 0) ? v + dead_amount : 0;
        return 0;
    endfunction

    function automatic t_move condition_report(logic [15:0] dx_raw, logic [15:0] dy_raw,
                                               logic active);
        longint dx, dy, sx, sy, mx, my, ax, ay;
        t_move  mv;
        dx = longint'($signed(dx_raw));
        dy = longint'($signed(dy_raw));
        if (!active)
            return '0;
        if (smooth_on) begin
            sx = dx + last_dx;
            sy = dy + last_dy;
            last_dx = dx;
            last_dy = dy;
        end else begin
            sx = 2 * dx;
            sy = 2 * dy;
        end
        mx = scale_lane(sx, x_axis_gain);
        my = scale_lane(sy, y_axis_gain);
        if (dead_amount != 0) begin
            mx = shrink_dead(mx);
            my = shrink_dead(my);
        end
        if (bias_div != 0) begin
            ax = (mx < 0) ? -mx : mx;
            ay = (my < 0) ? -my : my;
            // On a tie the horizontal axis is the one divided.
            if (ax > ay)
                my = my / bias_div;
            else
                mx = mx / bias_div;
        end
        mv.move_x = mx[31:0];
        mv.move_y = my[31:0];
        return mv;
    endfunction

    function automatic t_stim_row reg_row(logic [mdc_pkg::CIDX_W-1:0] idx,
                                          logic [mdc_pkg::CDATA_W-1:0] val);
        t_stim_row r;
        r = '{kind: ROW_CFG, idx: idx, val: val, dx: '0, dy: '0, active: 1'b0,
              typed: 1'b0, typed_move: '0};
        return r;
    endfunction

    function automatic t_stim_row report_row(int dx, int dy, logic active, bit typed,
                                             int ex, int ey);
        t_stim_row r;
        r = '{kind: ROW_REPORT, idx: '0, val: '0, dx: dx[15:0], dy: dy[15:0],
              active: active, typed: typed, typed_move: {ey[31:0], ex[31:0]}};
        return r;
    endfunction

    task automatic write_reg(logic [mdc_pkg::CIDX_W-1:0] idx,
                             logic [mdc_pkg::CDATA_W-1:0] data);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b1;
        i_cfg_index     <= idx;
        i_cfg_data      <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            mdc_pkg::CFG_SMOOTH: smooth_on   = data[0];
            mdc_pkg::CFG_SENS:   sens_gain   = longint'($signed(data));
            mdc_pkg::CFG_XGAIN:  x_axis_gain = longint'($signed(data));
            mdc_pkg::CFG_YGAIN:  y_axis_gain = longint'($signed(data));
            mdc_pkg::CFG_DZONE:  dead_amount = longint'(data);
            mdc_pkg::CFG_BIAS:   bias_div    = longint'(data[mdc_pkg::BIAS_W-1:0]);
            default: ;
        endcase
        reg_writes++;
    endtask

    // Leaves the beat valid high after the handshake; the caller decides at the next
    // falling edge whether another beat follows or the line goes idle.
    task automatic send_report(logic [15:0] dx, logic [15:0] dy, logic active, bit typed,
                               t_move typed_move);
        t_move mv;
        @(negedge i_clk);
        i_cfg_valid     <= 1'b0;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {dy, dx};
        i_s_axis_tuser  <= active;
        do @(posedge i_clk); while (!o_s_axis_tready);
        mv = condition_report(dx, dy, active);
        expected_moves.push_back(typed ? typed_move : mv);
        beats_in++;
        if (active)
            beats_active++;
    endtask

    // Idle both inputs, wait for every outstanding result, then let the pipeline settle.
    task automatic drain_pipe();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        i_cfg_valid     <= 1'b0;
        while (expected_moves.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_delta();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            1, 2, 3: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 400)) - 200);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 2))
                    0: return 16'h8000;
                    1: return 16'h7FFF;
                    default: return 16'h0000;
                endcase
            end
            1, 2: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    // Receiver: switches between open, toggling, sparse and fully held stretches.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(4, 40);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_m_axis_tready <= 1'b1;
            RX_TOGGLE: i_m_axis_tready <= ~i_m_axis_tready;
            RX_SPARSE: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   i_m_axis_tready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_moves.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual x=%0d y=%0d",
                         $realtime, $signed(o_m_axis_tdata[31:0]),
                         $signed(o_m_axis_tdata[63:32]));
                fail_count++;
            end else begin
                t_move want;
                want = expected_moves.pop_front();
                if (o_m_axis_tdata[31:0] !== want.move_x) begin
                    $display("%0t: move_x mismatch, expected %0d actual %0d", $realtime,
                             $signed(want.move_x), $signed(o_m_axis_tdata[31:0]));
                    fail_count++;
                end
                if (o_m_axis_tdata[63:32] !== want.move_y) begin
                    $display("%0t: move_y mismatch, expected %0d actual %0d", $realtime,
                             $signed(want.move_y), $signed(o_m_axis_tdata[63:32]));
                    fail_count++;
                end
                moves_checked++;
            end
        end
    end

    initial begin
        bit                          last_was_cfg;
        int                          sent, burst, gap;
        logic [mdc_pkg::CDATA_W-1:0] dz_val, bias_val;

        smooth_on   = 1'b0;
        sens_gain   = 256;
        x_axis_gain = 256;
        y_axis_gain = 256;
        dead_amount = 0;
        bias_div    = 0;
        last_dx     = 0;
        last_dy     = 0;

        // Reset values: unit gains give 16 counts per raw count.
        directed_rows.push_back(report_row(1, -1, 1'b1, 1, 16, -16));
        directed_rows.push_back(report_row(32767, -32768, 1'b1, 1, 524272, -524288));
        directed_rows.push_back(report_row(123, -5, 1'b0, 1, 0, 0));
        // Extreme gains saturate in both directions.
        directed_rows.push_back(reg_row(mdc_pkg::CFG_SENS, 16'h8000));
        directed_rows.push_back(reg_row(mdc_pkg::CFG_XGAIN, 16'h8000));
        directed_rows.push_back(reg_row(mdc_pkg::CFG_YGAIN, 16'h7FFF));
        directed_rows.push_back(report_row(32767, 32767, 1'b1, 1,
                                           32'h7FFF_FFFF, 32'h8000_0000));
        directed_rows.push_back(report_row(-32768, -32768, 1'b1, 1,
                                           32'h8000_0000, 32'h7FFF_FFFF));
        directed_rows.push_back(reg_row(mdc_pkg::CFG_SENS, 16'd256));
        directed_rows.push_back(reg_row(mdc_pkg::CFG_XGAIN, 16'd256));
        directed_rows.push_back(reg_row(mdc_pkg::CFG_YGAIN, 16'd256));
        // Deadzone shrinks toward zero and never flips the sign.
        directed_rows.push_back(reg_row(mdc_pkg::CFG_DZONE, 16'd100));
        directed_rows.push_back(report_row(10, -3, 1'b1, 1, 60, 0));
        directed_rows.push_back(report_row(-10, 3, 1'b1, 1, -60, 0));
        directed_rows.push_back(reg_row(mdc_pkg::CFG_DZONE, 16'hFFFF));
        directed_rows.push_back(report_row(32767, -32768, 1'b1, 1, 458737, -458753));
        directed_rows.push_back(report_row(1000, -3, 1'b1, 0, 0, 0));
        // Bias divides the weaker axis; a tie divides the horizontal one.
        directed_rows.push_back(reg_row(mdc_pkg::CFG_DZONE, 16'd0));
        directed_rows.push_back(reg_row(mdc_pkg::CFG_BIAS, 16'd3));
        directed_rows.push_back(report_row(10, 4, 1'b1, 0, 0, 0));
        directed_rows.push_back(report_row(-4, -10, 1'b1, 0, 0, 0));
        directed_rows.push_back(report_row(5, -5, 1'b1, 0, 0, 0));
        directed_rows.push_back(reg_row(mdc_pkg::CFG_BIAS, 16'h12FF));
        directed_rows.push_back(report_row(32767, 1, 1'b1, 0, 0, 0));
        directed_rows.push_back(reg_row(mdc_pkg::CFG_BIAS, 16'd0));
        // Smoothing: history moves only on active reports with smoothing on.
        directed_rows.push_back(reg_row(mdc_pkg::CFG_SMOOTH, 16'd1));
        directed_rows.push_back(report_row(10, 20, 1'b1, 0, 0, 0));
        directed_rows.push_back(report_row(99, 99, 1'b0, 0, 0, 0));
        directed_rows.push_back(report_row(-10, 0, 1'b1, 0, 0, 0));
        directed_rows.push_back(report_row(32767, -32768, 1'b1, 0, 0, 0));
        directed_rows.push_back(report_row(32767, -32768, 1'b1, 0, 0, 0));
        directed_rows.push_back(reg_row(mdc_pkg::CFG_SMOOTH, 16'd0));
        directed_rows.push_back(report_row(3, 3, 1'b1, 0, 0, 0));
        // Writes past the last register are dropped.
        directed_rows.push_back(reg_row(CFG_SPARE6, 16'h0000));
        directed_rows.push_back(reg_row(CFG_SPARE7, 16'hFFFF));
        directed_rows.push_back(report_row(1, 1, 1'b1, 1, 16, 16));

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        last_was_cfg = 1'b0;
        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                if (!last_was_cfg) begin
                    drain_pipe();
                    settings_used++;
                end
                write_reg(directed_rows[k].idx, directed_rows[k].val);
                last_was_cfg = 1'b1;
            end else begin
                send_report(directed_rows[k].dx, directed_rows[k].dy,
                            directed_rows[k].active, directed_rows[k].typed,
                            directed_rows[k].typed_move);
                last_was_cfg = 1'b0;
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_pipe();
            settings_used++;
            if (ph == 0) begin
                write_reg(mdc_pkg::CFG_SMOOTH, 16'd1);
                write_reg(mdc_pkg::CFG_SENS, 16'h7FFF);
                write_reg(mdc_pkg::CFG_XGAIN, 16'h7FFF);
                write_reg(mdc_pkg::CFG_YGAIN, 16'h7FFF);
                write_reg(mdc_pkg::CFG_DZONE, 16'hFFFF);
                write_reg(mdc_pkg::CFG_BIAS, 16'h00FF);
            end else if (ph == 1) begin
                write_reg(mdc_pkg::CFG_SMOOTH, 16'd0);
                write_reg(mdc_pkg::CFG_SENS, 16'h8000);
                write_reg(mdc_pkg::CFG_XGAIN, 16'h8000);
                write_reg(mdc_pkg::CFG_YGAIN, 16'h8000);
                write_reg(mdc_pkg::CFG_DZONE, 16'h0000);
                write_reg(mdc_pkg::CFG_BIAS, 16'h0001);
            end else begin
                case ($urandom_range(0, 3))
                    0:       dz_val = 16'd0;
                    1:       dz_val = 16'hFFFF;
                    2:       dz_val = 16'($urandom);
                    default: dz_val = 16'($urandom_range(0, 2000));
                endcase
                case ($urandom_range(0, 4))
                    0, 1:    bias_val = 16'($urandom_range(0, 255)) << 8;
                    2:       bias_val = 16'h0001;
                    3:       bias_val = 16'h00FF;
                    default: bias_val = 16'($urandom);
                endcase
                write_reg(mdc_pkg::CFG_SMOOTH, 16'($urandom));
                write_reg(mdc_pkg::CFG_SENS, pick_gain());
                write_reg(mdc_pkg::CFG_XGAIN, pick_gain());
                write_reg(mdc_pkg::CFG_YGAIN, pick_gain());
                write_reg(mdc_pkg::CFG_DZONE, dz_val);
                write_reg(mdc_pkg::CFG_BIAS, bias_val);
                if ($urandom_range(0, 2) == 0)
                    write_reg($urandom_range(0, 1) ? CFG_SPARE6 : CFG_SPARE7, 16'($urandom));
            end

            sent = 0;
            while (sent < PHASE_REPORTS) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst; b++) begin
                    send_report(pick_delta(), pick_delta(), $urandom_range(0, 6) != 0,
                                1'b0, '0);
                    sent++;
                end
                // Now and then the sender waits until the output side has caught up.
                if ($urandom_range(0, 9) == 0) begin
                    drain_pipe();
                end else begin
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    if (gap > 0) begin
                        @(negedge i_clk);
                        i_s_axis_tvalid <= 1'b0;
                        repeat (gap - 1) @(negedge i_clk);
                    end
                end
            end
        end

        drain_pipe();

        $display("tb: %0d report beats sent (%0d active), %0d results checked",
                 beats_in, beats_active, moves_checked);
        $display("tb: %0d register writes across %0d settings, extremes included",
                 reg_writes, settings_used);
        if (fail_count == 0) begin
            $display("tb: PASS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
